// File: sv/fba_pkg.sv
// shared types and constants for the flagged block averager
// no dependencies; imported by every module of the block
package fba_pkg;

  localparam int ELEM_BITS    = 10;
  localparam int NUM_ELEMENTS = 1024;
  localparam int SAMPLE_BITS  = 24;
  localparam int SUM_BITS     = 32;
  localparam int CNT_BITS     = 9;
  localparam int MAX_BLOCK    = 256;
  localparam int QDEPTH       = 4;
  localparam int QPTR_BITS    = $clog2(QDEPTH);
  localparam int STEP_BITS    = $clog2(SUM_BITS);

  // input word
  typedef struct packed {
    logic [ELEM_BITS-1:0]          elem_index;
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
    logic                          sample_valid;
    logic                          last_record;
  } in_item_t;

  // result word
  typedef struct packed {
    logic [ELEM_BITS-1:0]          out_index;
    logic signed [SAMPLE_BITS-1:0] avg_re;
    logic signed [SAMPLE_BITS-1:0] avg_im;
    logic                          avg_valid;
  } out_item_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_EMIT
  } fba_state_t;

endpackage

// File: sv/fba_front.sv
// front end: accepts input words, drops out-of-range indexes, queues the rest
// depends on fba_pkg
module fba_front import fba_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  in_item_t item,
  input  logic     clearing,
  output logic     job_valid,
  input  logic     job_take,
  output in_item_t job
);

  in_item_t             q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 in_range;
  logic                 do_push;
  logic                 do_pop;

  assign full      = clearing || (count == (QPTR_BITS+1)'(QDEPTH));
  assign in_range  = {1'b0, item.elem_index} < (ELEM_BITS+1)'(NUM_ELEMENTS);
  assign do_push   = push && !full && in_range;
  assign job_valid = (count != '0);
  assign do_pop    = job_take && job_valid;
  assign job       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: sv/fba_div.sv
// iterative restoring divider, two lanes sharing one divisor, one bit per cycle
// quotient truncates toward zero and is clamped to the sample range; uses fba_pkg
module fba_div import fba_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic signed [SUM_BITS-1:0]    num_re,
  input  logic signed [SUM_BITS-1:0]    num_im,
  input  logic [CNT_BITS-1:0]           den,
  output logic                          done,
  output logic signed [SAMPLE_BITS-1:0] q_re,
  output logic signed [SAMPLE_BITS-1:0] q_im
);

  localparam logic [SUM_BITS-1:0] POS_LIM = SUM_BITS'(2**(SAMPLE_BITS-1) - 1);
  localparam logic [SUM_BITS-1:0] NEG_LIM = SUM_BITS'(2**(SAMPLE_BITS-1));

  logic                  busy;
  logic [STEP_BITS-1:0]  step;
  logic [CNT_BITS-1:0]   den_r;
  logic [SUM_BITS-1:0]   mag_re;
  logic [SUM_BITS-1:0]   mag_im;
  logic [CNT_BITS:0]     rem_re;
  logic [CNT_BITS:0]     rem_im;
  logic                  neg_re;
  logic                  neg_im;
  logic [CNT_BITS+SUM_BITS:0] nx_re;
  logic [CNT_BITS+SUM_BITS:0] nx_im;

  function automatic logic [SUM_BITS-1:0] abs_val(input logic signed [SUM_BITS-1:0] x);
    abs_val = x[SUM_BITS-1] ? (~x + 1'b1) : x;
  endfunction

  // one restoring step: returns {remainder, shifted quotient}
  function automatic logic [CNT_BITS+SUM_BITS:0] div_step(
    input logic [CNT_BITS:0]   rem,
    input logic [SUM_BITS-1:0] mag,
    input logic [CNT_BITS-1:0] d
  );
    logic [CNT_BITS:0] sh;
    logic              ge;
    sh = {rem[CNT_BITS-1:0], mag[SUM_BITS-1]};
    ge = (sh >= {1'b0, d});
    div_step = {(ge ? (sh - {1'b0, d}) : sh), mag[SUM_BITS-2:0], ge};
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] clamp(
    input logic [SUM_BITS-1:0] mag,
    input logic                neg
  );
    if (neg) begin
      clamp = (mag > NEG_LIM) ? NEG_LIM[SAMPLE_BITS-1:0]
                              : (~mag[SAMPLE_BITS-1:0] + 1'b1);
    end else begin
      clamp = (mag > POS_LIM) ? POS_LIM[SAMPLE_BITS-1:0] : mag[SAMPLE_BITS-1:0];
    end
  endfunction

  assign nx_re = div_step(rem_re, mag_re, den_r);
  assign nx_im = div_step(rem_im, mag_im, den_r);
  assign q_re  = clamp(mag_re, neg_re);
  assign q_im  = clamp(mag_im, neg_im);

  always_ff @(posedge clk) begin
    if (start) begin
      mag_re <= abs_val(num_re);
      mag_im <= abs_val(num_im);
      neg_re <= num_re[SUM_BITS-1];
      neg_im <= num_im[SUM_BITS-1];
      rem_re <= '0;
      rem_im <= '0;
      den_r  <= den;
    end else if (busy) begin
      {rem_re, mag_re} <= nx_re;
      {rem_im, mag_im} <= nx_im;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_BITS'(SUM_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: sv/fba_accum.sv
// back end: per-element sum/count memory, read-modify-write sequencer, clearing pass
// depends on fba_pkg and fba_div
module fba_accum import fba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  output logic      clearing,
  input  logic      job_valid,
  output logic      job_take,
  input  in_item_t  job,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res
);

  typedef struct packed {
    logic signed [SUM_BITS-1:0] sre;
    logic signed [SUM_BITS-1:0] sim;
    logic [CNT_BITS-1:0]        cnt;
  } entry_t;

  entry_t               mem [NUM_ELEMENTS];
  entry_t               rd_data;
  entry_t               wd;
  logic                 we;
  logic [ELEM_BITS-1:0] wa;

  fba_state_t           state;
  fba_state_t           state_next;
  logic [ELEM_BITS-1:0] clr_addr;
  in_item_t             cur;

  logic                       add_ok;
  logic signed [SUM_BITS-1:0] new_re;
  logic signed [SUM_BITS-1:0] new_im;
  logic [CNT_BITS-1:0]        cnt_new;
  logic                       div_start;
  logic                       div_done;
  logic signed [SAMPLE_BITS-1:0] q_re;
  logic signed [SAMPLE_BITS-1:0] q_im;

  function automatic logic signed [SUM_BITS-1:0] add_sat(
    input logic signed [SUM_BITS-1:0]    acc,
    input logic signed [SAMPLE_BITS-1:0] x
  );
    logic [SUM_BITS:0] s;
    s = {acc[SUM_BITS-1], acc} + {{(SUM_BITS+1-SAMPLE_BITS){x[SAMPLE_BITS-1]}}, x};
    if (s[SUM_BITS] != s[SUM_BITS-1]) begin
      add_sat = s[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      add_sat = s[SUM_BITS-1:0];
    end
  endfunction

  // memory: one write port, one registered read port addressed by the queue head
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[job.elem_index];
  end

  assign add_ok  = cur.sample_valid && (rd_data.cnt < CNT_BITS'(MAX_BLOCK));
  assign new_re  = add_ok ? add_sat(rd_data.sre, cur.sample_re) : rd_data.sre;
  assign new_im  = add_ok ? add_sat(rd_data.sim, cur.sample_im) : rd_data.sim;
  assign cnt_new = add_ok ? (rd_data.cnt + 1'b1) : rd_data.cnt;

  assign clearing  = (state == ST_CLEAR);
  assign res_valid = (state == ST_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    wa         = cur.elem_index;
    wd         = '0;
    job_take   = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        we = 1'b1;
        wa = clr_addr;
        if (clr_addr == ELEM_BITS'(NUM_ELEMENTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (job_valid) begin
          job_take   = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        we = 1'b1;
        if (!cur.last_record) begin
          wd         = '{sre: new_re, sim: new_im, cnt: cnt_new};
          state_next = ST_IDLE;
        end else if (cnt_new == '0) begin
          state_next = ST_EMIT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      cur <= job;
    end
    if (state == ST_UPDATE && cur.last_record) begin
      res.out_index <= cur.elem_index;
      res.avg_valid <= (cnt_new != '0);
      res.avg_re    <= '0;
      res.avg_im    <= '0;
    end else if (state == ST_DIV && div_done) begin
      res.avg_re <= q_re;
      res.avg_im <= q_im;
    end
  end

  fba_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num_re (new_re),
    .num_im (new_im),
    .den    (cnt_new),
    .done   (div_done),
    .q_re   (q_re),
    .q_im   (q_im)
  );

endmodule

// File: sv/flagged_block_averager_core.sv
// top level of the flagged block averager: input queue, accumulator back end,
// result register; depends on fba_pkg, fba_front, fba_accum, fba_div
//
// Time-integrates complex samples per element (1024 elements). A word with
// sample_valid set adds its real and imaginary parts to the element's 32-bit
// saturating sums and bumps its count, up to 256 valid samples per block;
// later valid samples are dropped. A word with last_record set (after adding
// its own sample) gives one result word: sum / count truncated toward zero
// and clamped to 24 bits, with avg_valid set, or zeros with avg_valid clear
// when the block held no valid samples; the element is then cleared. Words
// with last_record clear give no result. After reset a clearing pass writes
// all 1024 elements, one per cycle, and full stays high throughout the pass.
// Then an accumulating word gets a memory read, then an update and write
// back in the back end; a closing word with valid samples also runs the
// shared bit-serial divider, which makes 32 quotient bits for both lanes at
// one bit per cycle. A 4-word input queue keeps push open while the back end
// works, until it fills; a one-word result register holds a finished result
// until pop, so the back end only stalls when that register is still full.
module flagged_block_averager_core import fba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  in_item_t  item,
  output logic      empty,
  input  logic      pop,
  output out_item_t result
);

  // front to back queue head
  logic      clearing;
  logic      job_valid;
  logic      job_take;
  in_item_t  job;

  // back end result handoff
  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  // result register
  logic      out_full;

  fba_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .clearing  (clearing),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job)
  );

  fba_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .clearing  (clearing),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // the back end hands over only into an empty result register
  assign res_ready = !out_full;
  assign empty     = !out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_full <= 1'b1;
    end else if (pop && out_full) begin
      out_full <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      result <= res;
    end
  end

endmodule
